/* sv/cdf_pkg.sv */
// Shared types, constants and helpers for the chunked transfer deframer.
// No dependencies; used by cdf_parse, cdf_out_stage, the top level and the testbench.
`default_nettype none

package cdf_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam logic [31:0] MAX_CHUNK_RST = 32'hFFFF_FFFF;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_LF = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_TERM_CR = 3'd5,
    PH_TERM_LF = 3'd6,
    PH_ERR     = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        is_payload;
    logic        header_done;
    logic [31:0] chunk_length;
    logic        last_of_chunk;
    logic        message_done;
    logic        malformed;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* sv/cdf_in_stage.sv */
// Input register of the deframer: holds one accepted byte for the parser.
// Depends on nothing beyond its ports.
`default_nettype none

module cdf_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       go,
  output logic            s1_valid,
  output logic [7:0]      s1_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  assign in_stall = valid_r && !go;
  assign accept   = in_valid && !in_stall;
  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (go) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
    end
  end

endmodule

`default_nettype wire

/* sv/cdf_parse.sv */
// Framing parser: phase, size/remaining count, digit count and size limit.
// Uses cdf_pkg for the phase type, byte codes, result struct and hex decode.
`default_nettype none

module cdf_parse #(
  parameter int SIZE_BITS = cdf_pkg::SIZE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        step,
  input  wire logic [7:0]  cur_byte,
  output cdf_pkg::result_t res
);

  localparam int CMP_W = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  cdf_pkg::phase_t       phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]  size_r, size_nxt;
  logic [1:0]            dcnt_r, dcnt_nxt;
  logic [31:0]           max_r;
  cdf_pkg::hex_t         hx;
  logic [SIZE_BITS-1:0]  shifted;
  logic [SIZE_BITS-1:0]  size_dec;
  logic [CMP_W-1:0]      nv_ext, max_ext, len_ext;
  logic                  bad;

  assign hx       = cdf_pkg::hex_decode(cur_byte);
  assign shifted  = {size_r[SIZE_BITS-5:0], hx.value};
  assign size_dec = size_r - SIZE_BITS'(1);
  assign nv_ext   = CMP_W'(shifted);
  assign max_ext  = CMP_W'(max_r);
  assign len_ext  = CMP_W'(size_r);

  always_comb begin
    phase_nxt = phase_r;
    size_nxt  = size_r;
    dcnt_nxt  = dcnt_r;
    bad       = 1'b0;
    res              = '0;
    res.data         = cur_byte;
    case (phase_r)
      cdf_pkg::PH_SIZE: begin
        if (cur_byte == cdf_pkg::CH_CR) begin
          if (dcnt_r == 2'd0) begin
            bad = 1'b1;
          end else if (size_r == '0 && dcnt_r > 2'd1) begin
            bad = 1'b1;
          end else begin
            phase_nxt = cdf_pkg::PH_SIZE_LF;
          end
        end else if (!hx.ok) begin
          bad = 1'b1;
        end else if (size_r[SIZE_BITS-1 -: 4] != 4'd0) begin
          bad = 1'b1;
        end else if (nv_ext > max_ext) begin
          bad = 1'b1;
        end else begin
          size_nxt = shifted;
          if (dcnt_r != 2'd3) begin
            dcnt_nxt = dcnt_r + 2'd1;
          end
        end
      end
      cdf_pkg::PH_SIZE_LF: begin
        if (cur_byte != cdf_pkg::CH_LF) begin
          bad = 1'b1;
        end else if (size_r == '0) begin
          phase_nxt = cdf_pkg::PH_TERM_CR;
        end else begin
          res.header_done  = 1'b1;
          res.chunk_length = len_ext[31:0];
          phase_nxt        = cdf_pkg::PH_DATA;
        end
      end
      cdf_pkg::PH_DATA: begin
        res.is_payload = 1'b1;
        size_nxt       = size_dec;
        if (size_dec == '0) begin
          phase_nxt = cdf_pkg::PH_DATA_CR;
        end
      end
      cdf_pkg::PH_DATA_CR: begin
        if (cur_byte != cdf_pkg::CH_CR) begin
          bad = 1'b1;
        end else begin
          phase_nxt = cdf_pkg::PH_DATA_LF;
        end
      end
      cdf_pkg::PH_DATA_LF: begin
        if (cur_byte != cdf_pkg::CH_LF) begin
          bad = 1'b1;
        end else begin
          res.last_of_chunk = 1'b1;
          phase_nxt         = cdf_pkg::PH_SIZE;
          size_nxt          = '0;
          dcnt_nxt          = 2'd0;
        end
      end
      cdf_pkg::PH_TERM_CR: begin
        if (cur_byte != cdf_pkg::CH_CR) begin
          bad = 1'b1;
        end else begin
          phase_nxt = cdf_pkg::PH_TERM_LF;
        end
      end
      cdf_pkg::PH_TERM_LF: begin
        if (cur_byte != cdf_pkg::CH_LF) begin
          bad = 1'b1;
        end else begin
          res.message_done = 1'b1;
          phase_nxt        = cdf_pkg::PH_SIZE;
          size_nxt         = '0;
          dcnt_nxt         = 2'd0;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    if (bad) begin
      phase_nxt = cdf_pkg::PH_ERR;
    end
    res.malformed = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cdf_pkg::PH_SIZE;
      size_r  <= '0;
      dcnt_r  <= 2'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      size_r  <= size_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= cdf_pkg::MAX_CHUNK_RST;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

/* sv/cdf_out_stage.sv */
// Result register of the deframer: holds one finished result until taken.
// Uses cdf_pkg::result_t.
`default_nettype none

module cdf_out_stage (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire cdf_pkg::result_t res,
  output logic             go,
  output logic             out_valid,
  input  wire logic        out_stall,
  output cdf_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  cdf_pkg::result_t res_r;

  assign go        = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

/* sv/chunked_transfer_deframer.sv */
// Top level of the chunked transfer deframer: input register, parser, result register.
// Depends on cdf_pkg, cdf_in_stage, cdf_parse and cdf_out_stage.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_byte
//   out      out_valid / out_stall out_byte, out_byte_is_payload, out_header_done,
//                                  out_chunk_length, out_last_of_chunk,
//                                  out_message_done, out_malformed
//   cfg      cfg_wr_en             cfg_wr_data (max chunk size)
//
// One byte per cycle sustained while out_stall is low; a taken byte is registered
// in the input register, then in the result register. The parser state updates as
// the byte moves between them, so the whole per-byte step is combinational logic.
// Synchronous reset returns to the size phase and sets the size limit to all ones.
// A stalled result holds both registers; in_stall rises only when both are full.
`default_nettype none

module chunked_transfer_deframer #(
  parameter int SIZE_BITS = cdf_pkg::SIZE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_is_payload,
  output logic             out_header_done,
  output logic [31:0]      out_chunk_length,
  output logic             out_last_of_chunk,
  output logic             out_message_done,
  output logic             out_malformed
);

  logic             go;
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             step;
  cdf_pkg::result_t res;
  cdf_pkg::result_t out_res;

  assign step = s1_valid && go;

  cdf_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .go       (go),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  cdf_parse #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .cur_byte    (s1_byte),
    .res         (res)
  );

  cdf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .go        (go),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte            = out_res.data;
  assign out_byte_is_payload = out_res.is_payload;
  assign out_header_done     = out_res.header_done;
  assign out_chunk_length    = out_res.chunk_length;
  assign out_last_of_chunk   = out_res.last_of_chunk;
  assign out_message_done    = out_res.message_done;
  assign out_malformed       = out_res.malformed;

endmodule

`default_nettype wire

/* test/testbench.sv */
// Testbench for chunked_transfer_deframer: chunked bodies under random stalls on both
// sides, each result checked field by field against an in-bench parser.
// Depends on cdf_pkg and the chunked_transfer_deframer RTL.
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BODY_BYTES = 1100;

  typedef enum int {
    FAULT_EMPTY_SIZE,
    FAULT_NON_HEX,
    FAULT_ZERO_DIGITS,
    FAULT_OVERSIZE,
    FAULT_WIDE_SIZE,
    FAULT_ZERO_LIMIT,
    FAULT_SIZE_LF,
    FAULT_DATA_CR,
    FAULT_DATA_LF,
    FAULT_TERM_CR,
    FAULT_TERM_LF,
    FAULT_BIG_HEADER
  } fault_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_byte_is_payload;
  logic        out_header_done;
  logic [31:0] out_chunk_length;
  logic        out_last_of_chunk;
  logic        out_message_done;
  logic        out_malformed;

  chunked_transfer_deframer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_byte_is_payload (out_byte_is_payload),
    .out_header_done     (out_header_done),
    .out_chunk_length    (out_chunk_length),
    .out_last_of_chunk   (out_last_of_chunk),
    .out_message_done    (out_message_done),
    .out_malformed       (out_malformed)
  );

  logic [7:0]       byte_queue[$];
  cdf_pkg::result_t expected_q[$];

  cdf_pkg::phase_t frame_phase;
  logic [63:0]     size_left;
  logic [1:0]      digit_cnt;
  logic [31:0]     size_limit;

  int               fail_count;
  int               cycle_count;
  int               bytes_queued;
  int               tx_gap;
  int               rx_hold;
  logic             quiet;
  cdf_pkg::result_t exp_r;

  function automatic cdf_pkg::result_t predict_deframe(input logic [7:0] c);
    cdf_pkg::result_t r;
    logic             fault;
    logic             hex_ok;
    logic [3:0]       nib;
    logic [63:0]      nv;
    r = '0;
    r.data = c;
    fault = 1'b0;
    hex_ok = 1'b1;
    nib = 4'd0;
    case (frame_phase)
      cdf_pkg::PH_SIZE: begin
        if (c == cdf_pkg::CH_CR) begin
          if (digit_cnt == 0) fault = 1'b1;
          else if (size_left == 0 && digit_cnt > 1) fault = 1'b1;
          else frame_phase = cdf_pkg::PH_SIZE_LF;
        end else begin
          if (c >= "0" && c <= "9") nib = 4'(c - 8'h30);
          else if (c >= "a" && c <= "f") nib = 4'(c - 8'h57);
          else if (c >= "A" && c <= "F") nib = 4'(c - 8'h37);
          else hex_ok = 1'b0;
          if (!hex_ok) begin
            fault = 1'b1;
          end else if (size_left[63:28] != 0) begin
            fault = 1'b1;
          end else begin
            nv = {size_left[59:0], nib};
            if (nv > {32'd0, size_limit}) begin
              fault = 1'b1;
            end else begin
              size_left = nv;
              if (digit_cnt < 3) digit_cnt = digit_cnt + 1'b1;
            end
          end
        end
      end
      cdf_pkg::PH_SIZE_LF: begin
        if (c != cdf_pkg::CH_LF) fault = 1'b1;
        else if (size_left == 0) frame_phase = cdf_pkg::PH_TERM_CR;
        else begin
          r.header_done = 1'b1;
          r.chunk_length = size_left[31:0];
          frame_phase = cdf_pkg::PH_DATA;
        end
      end
      cdf_pkg::PH_DATA: begin
        r.is_payload = 1'b1;
        size_left = size_left - 1;
        if (size_left == 0) frame_phase = cdf_pkg::PH_DATA_CR;
      end
      cdf_pkg::PH_DATA_CR: begin
        if (c != cdf_pkg::CH_CR) fault = 1'b1;
        else frame_phase = cdf_pkg::PH_DATA_LF;
      end
      cdf_pkg::PH_DATA_LF: begin
        if (c != cdf_pkg::CH_LF) fault = 1'b1;
        else begin
          r.last_of_chunk = 1'b1;
          frame_phase = cdf_pkg::PH_SIZE;
          size_left = '0;
          digit_cnt = '0;
        end
      end
      cdf_pkg::PH_TERM_CR: begin
        if (c != cdf_pkg::CH_CR) fault = 1'b1;
        else frame_phase = cdf_pkg::PH_TERM_LF;
      end
      cdf_pkg::PH_TERM_LF: begin
        if (c != cdf_pkg::CH_LF) fault = 1'b1;
        else begin
          r.message_done = 1'b1;
          frame_phase = cdf_pkg::PH_SIZE;
          size_left = '0;
          digit_cnt = '0;
        end
      end
      default: fault = 1'b1;
    endcase
    if (fault) frame_phase = cdf_pkg::PH_ERR;
    r.malformed = fault;
    return r;
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == x) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_queue.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_size_line(input logic [31:0] value, input int zeros);
    int         n;
    int         i;
    logic [3:0] nib;
    n = 1;
    for (i = 1; i < 8; i++) if (value[4*i +: 4] != 0) n = i + 1;
    repeat (zeros) push_byte("0");
    for (i = n - 1; i >= 0; i--) begin
      nib = value[4*i +: 4];
      if (nib < 10) push_byte(8'h30 + nib);
      else push_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
    end
    push_byte(cdf_pkg::CH_CR);
    push_byte(cdf_pkg::CH_LF);
  endtask

  task automatic push_chunk(input int len);
    push_size_line(len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    repeat (len) push_byte(8'($urandom_range(0, 255)));
    push_byte(cdf_pkg::CH_CR);
    push_byte(cdf_pkg::CH_LF);
  endtask

  task automatic push_terminator();
    push_byte("0");
    push_byte(cdf_pkg::CH_CR);
    push_byte(cdf_pkg::CH_LF);
    push_byte(cdf_pkg::CH_CR);
    push_byte(cdf_pkg::CH_LF);
  endtask

  task automatic push_message(input int max_len);
    int len;
    if (max_len > 0) begin
      repeat ($urandom_range(0, 3)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        if (len > max_len) len = $urandom_range(1, max_len);
        push_chunk(len);
      end
    end
    push_terminator();
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    size_limit = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_byte = '0;
    out_stall = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    bytes_queued = 0;
    tx_gap = 0;
    rx_hold = 0;
    quiet = 1'b0;
    frame_phase = cdf_pkg::PH_SIZE;
    size_left = '0;
    digit_cnt = '0;
    size_limit = cdf_pkg::MAX_CHUNK_RST;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(predict_deframe(in_byte));
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_byte <= byte_queue.pop_front();
          tx_gap = quiet ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("out_byte: no item outstanding, got %0h", out_byte);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("out_byte", exp_r.data, out_byte);
          check_field("byte_is_payload", exp_r.is_payload, out_byte_is_payload);
          check_field("header_done", exp_r.header_done, out_header_done);
          check_field("chunk_length", exp_r.chunk_length, out_chunk_length);
          check_field("last_of_chunk", exp_r.last_of_chunk, out_last_of_chunk);
          check_field("message_done", exp_r.message_done, out_message_done);
          check_field("malformed", exp_r.malformed, out_malformed);
        end
        rx_hold = quiet ? 0 : $urandom_range(0, 4);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold != 0);
    end
  end

  initial begin
    fault_t      fault;
    logic [31:0] lim;
    logic [7:0]  b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_terminator();
    push_byte("0");
    push_byte("0");
    push_byte("1");
    push_byte(cdf_pkg::CH_CR);
    push_byte(cdf_pkg::CH_LF);
    push_byte(8'hFF);
    push_byte(cdf_pkg::CH_CR);
    push_byte(cdf_pkg::CH_LF);
    push_byte("2");
    push_byte(cdf_pkg::CH_CR);
    push_byte(cdf_pkg::CH_LF);
    push_byte(8'h00);
    push_byte(cdf_pkg::CH_CR);
    push_byte(cdf_pkg::CH_CR);
    push_byte(cdf_pkg::CH_LF);
    push_terminator();
    repeat (8) push_message(64);

    write_limit(32'd1);
    repeat (10) push_message(1);

    lim = $urandom_range(2, 300);
    write_limit(lim);
    repeat (10) push_message((lim > 64) ? 64 : int'(lim));

    write_limit(32'd0);
    repeat (3) push_message(0);

    write_limit(32'hFFFF_FFFF);
    while (bytes_queued < BODY_BYTES) push_message(64);
    drain();

    fault = fault_t'($urandom_range(0, FAULT_BIG_HEADER));
    case (fault)
      FAULT_EMPTY_SIZE: push_byte(cdf_pkg::CH_CR);
      FAULT_NON_HEX: begin
        if ($urandom_range(0, 1)) push_byte("7");
        b = 8'($urandom_range(0, 255));
        while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
               (b >= "A" && b <= "F") || b == cdf_pkg::CH_CR) b = 8'($urandom_range(0, 255));
        push_byte(b);
      end
      FAULT_ZERO_DIGITS: begin
        repeat ($urandom_range(2, 4)) push_byte("0");
        push_byte(cdf_pkg::CH_CR);
      end
      FAULT_OVERSIZE: begin
        lim = $urandom_range(1, 4095);
        write_limit(lim);
        push_size_line(lim + $urandom_range(1, 100), 0);
      end
      FAULT_WIDE_SIZE: begin
        push_byte("1");
        repeat (8) push_byte("0");
      end
      FAULT_ZERO_LIMIT: begin
        write_limit(32'd0);
        push_size_line(32'd1, 0);
      end
      FAULT_SIZE_LF: begin
        push_byte("5");
        push_byte(cdf_pkg::CH_CR);
        push_byte(other_than(cdf_pkg::CH_LF));
      end
      FAULT_DATA_CR: begin
        push_size_line(32'd2, 0);
        repeat (2) push_byte(8'($urandom_range(0, 255)));
        push_byte(other_than(cdf_pkg::CH_CR));
      end
      FAULT_DATA_LF: begin
        push_size_line(32'd2, 0);
        repeat (2) push_byte(8'($urandom_range(0, 255)));
        push_byte(cdf_pkg::CH_CR);
        push_byte(other_than(cdf_pkg::CH_LF));
      end
      FAULT_TERM_CR: begin
        push_byte("0");
        push_byte(cdf_pkg::CH_CR);
        push_byte(cdf_pkg::CH_LF);
        push_byte(other_than(cdf_pkg::CH_CR));
      end
      FAULT_TERM_LF: begin
        push_byte("0");
        push_byte(cdf_pkg::CH_CR);
        push_byte(cdf_pkg::CH_LF);
        push_byte(cdf_pkg::CH_CR);
        push_byte(other_than(cdf_pkg::CH_LF));
      end
      default: push_size_line(32'hFFFF_FFFF, 0);
    endcase
    repeat (24) push_byte(8'($urandom_range(0, 255)));
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* chunked_transfer_deframer.f */
sv/cdf_pkg.sv
sv/cdf_in_stage.sv
sv/cdf_parse.sv
sv/cdf_out_stage.sv
sv/chunked_transfer_deframer.sv
test/testbench.sv
